// ===== rtl/qtcn_pkg.sv =====
package qtcn_pkg;

  localparam int SINE_DEPTH     = 1024;
  localparam int SINE_AW        = $clog2(SINE_DEPTH);
  localparam int QTR_DEPTH      = SINE_DEPTH / 4;
  localparam int QTR_AW         = SINE_AW - 2;
  localparam int PEAK_AMPLITUDE = 19660;

  localparam int VEL_W   = 20;
  localparam int STEP_W  = 24;
  localparam int PHASE_W = 16;
  localparam int AMP_W   = 23;
  localparam int SMP_W   = 16;
  localparam int ROM_W   = 15;
  localparam int MUL_W   = 24;
  localparam int PROD_W  = 2 * MUL_W;

  localparam logic [AMP_W-1:0] AMP_PEAK   = AMP_W'(PEAK_AMPLITUDE * 256);
  localparam logic [VEL_W-1:0] DEAD_ZONE  = VEL_W'(102);
  localparam logic [MUL_W-1:0] DECAY_NUM  = MUL_W'(64225);
  localparam logic [MUL_W-1:0] AMP_RATE   = MUL_W'(13107);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAD_270     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_TIMEOUT = 3'd3;

  localparam logic [23:0] STEP_GAIN_RST    = 24'd483189;
  localparam logic [15:0] LINK_TIMEOUT_RST = 16'd3000;

  typedef struct packed {
    logic                    block_start;
    logic [31:0]             now_ms;
    logic [31:0]             last_packet_ms;
    logic signed [VEL_W-1:0] rx_velocity;
  } req_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] left_sample;
    logic signed [SMP_W-1:0] right_sample;
    logic                    carrier_active;
  } rsp_t;

  // quarter wave of the sine table, q30 taylor series
  typedef logic [ROM_W-1:0] qtab_t [QTR_DEPTH];

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam longint unsigned TAYLOR_DIV [1:12] =
    '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600};

  function automatic qtab_t build_qtab();
    qtab_t       tab;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    for (int k = 0; k < QTR_DEPTH; k++) begin
      x    = (64'(2 * k + 1) * PI_Q30) / SINE_DEPTH;
      term = x;
      sum  = x;
      for (int n = 1; n <= 12; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / TAYLOR_DIV[n];
        if ((n % 2) == 1) begin
          sum = (sum > term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      sum = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
      if (sum > 64'd32767) begin
        sum = 64'd32767;
      end
      tab[k] = ROM_W'(sum);
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

endpackage

// ===== rtl/quadrature_timecode_carrier_nco.sv =====
// quadrature carrier nco with link-timeout velocity decay
// req channel (req_valid / req_stall / req): one word per output sample tick.
//   a word is taken when req_valid is high and req_stall is low. req_stall
//   is high while a word is being worked on.
// rsp channel (rsp_valid / rsp_stall / rsp): one word per request word,
//   held in an output register until taken (rsp_valid high, rsp_stall low).
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register writes,
//   always ready; write only while the block is idle.
// steps: a plain tick runs the amplitude, sine and cosine steps; block_start on
//   a fresh link adds the phase step, and on a stale link the velocity decay
//   before it. a new request is taken only after the response is loaded, so
//   the block never works on two words at once.
// all products (velocity decay, phase step, amplitude ramp, sine and cosine
//   scaling) run through one registered 24x24 magnitude multiplier, one
//   product per cycle, which sets the order of these steps.
// if the receiver stalls, the finished word waits in the output register and
//   the next request is still taken; its result waits in the last step until
//   the register frees up.
// reset (synchronous, rst high) clears velocity, step, phase, amplitude and
//   the active flag, and loads the register defaults.
module quadrature_timecode_carrier_nco import qtcn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_VEL      = 4'd1;
  localparam logic [3:0] S_DECAY_WB = 4'd2;
  localparam logic [3:0] S_STEP_MUL = 4'd3;
  localparam logic [3:0] S_STEP_WB  = 4'd4;
  localparam logic [3:0] S_AMP_MUL  = 4'd5;
  localparam logic [3:0] S_AMP_WB   = 4'd6;
  localparam logic [3:0] S_SIN_MUL  = 4'd7;
  localparam logic [3:0] S_COS_MUL  = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state;

  logic [23:0] step_gain;
  logic        quadrature_270;
  logic        swap_channels;
  logic [15:0] link_timeout;

  logic signed [VEL_W-1:0]  ev;
  logic signed [STEP_W-1:0] carrier_step;
  logic [PHASE_W-1:0]       phase;
  logic [AMP_W-1:0]         amp;
  logic                     active;

  req_t              req_q;
  logic [PROD_W-1:0] prod;
  logic              prod_neg;
  logic [ROM_W-1:0]  rom_s_mag;
  logic              rom_s_neg;
  logic [ROM_W-1:0]  rom_c_mag;
  logic              rom_c_neg;
  logic [SMP_W-1:0]  sin_sample;

  logic                    fresh;
  logic [VEL_W-1:0]        ev_mag;
  logic signed [AMP_W:0]   amp_diff;
  logic [AMP_W-1:0]        amp_diff_mag;
  logic [VEL_W-1:0]        decay_mag;
  logic [VEL_W-1:0]        step_mag;
  logic [AMP_W-1:0]        amp_delta;
  logic [SMP_W-1:0]        prod_sample;
  logic                    out_free;

  logic [SINE_AW-1:0] sin_idx;
  logic [SINE_AW-1:0] cos_idx;
  logic [SINE_AW-1:0] rom_idx;
  logic [QTR_AW-1:0]  qtr_idx;
  logic [ROM_W-1:0]   rom_mag;
  logic               rom_neg;

  logic              mul_en;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic              mul_neg;

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !rsp_valid || !rsp_stall;

  assign fresh        = (req_q.now_ms - req_q.last_packet_ms) <= {16'd0, link_timeout};
  assign ev_mag       = ev[VEL_W-1] ? VEL_W'(-ev) : VEL_W'(ev);
  assign amp_diff     = signed'({1'b0, (active ? AMP_PEAK : AMP_W'(0))})
                      - signed'({1'b0, amp});
  assign amp_diff_mag = amp_diff[AMP_W] ? AMP_W'(-amp_diff) : AMP_W'(amp_diff);

  assign decay_mag   = prod[16 +: VEL_W];
  assign step_mag    = prod[24 +: VEL_W];
  assign amp_delta   = prod[16 +: AMP_W];
  assign prod_sample = prod_neg ? SMP_W'(-prod[23 +: SMP_W]) : prod[23 +: SMP_W];

  // quarter-wave table lookup
  assign sin_idx = phase[PHASE_W-1 -: SINE_AW];
  assign cos_idx = sin_idx + (quadrature_270 ? SINE_AW'(3 * SINE_DEPTH / 4)
                                             : SINE_AW'(SINE_DEPTH / 4));
  assign rom_idx = (state == S_AMP_MUL) ? sin_idx : cos_idx;
  assign rom_neg = rom_idx[SINE_AW-1];
  assign qtr_idx = rom_idx[SINE_AW-2] ? ~rom_idx[QTR_AW-1:0] : rom_idx[QTR_AW-1:0];
  assign rom_mag = QTAB[qtr_idx];

  // shared multiplier operand select
  always_comb begin
    mul_en  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    unique case (state)
      S_VEL: begin
        mul_en  = req_q.block_start && !fresh;
        mul_a   = MUL_W'(ev_mag);
        mul_b   = DECAY_NUM;
        mul_neg = ev[VEL_W-1];
      end
      S_STEP_MUL: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'(ev_mag);
        mul_b   = step_gain;
        mul_neg = ev[VEL_W-1];
      end
      S_AMP_MUL: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'(amp_diff_mag);
        mul_b   = AMP_RATE;
        mul_neg = amp_diff[AMP_W];
      end
      S_SIN_MUL: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'(rom_s_mag);
        mul_b   = MUL_W'(amp);
        mul_neg = rom_s_neg;
      end
      S_COS_MUL: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'(rom_c_mag);
        mul_b   = MUL_W'(amp);
        mul_neg = !rom_c_neg;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // datapath words
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q <= req;
    end
    if (mul_en) begin
      prod     <= PROD_W'(mul_a) * PROD_W'(mul_b);
      prod_neg <= mul_neg;
    end
    if (state == S_AMP_MUL) begin
      rom_s_mag <= rom_mag;
      rom_s_neg <= rom_neg;
    end
    if (state == S_AMP_WB) begin
      rom_c_mag <= rom_mag;
      rom_c_neg <= rom_neg;
    end
    if (state == S_COS_MUL) begin
      sin_sample <= prod_sample;
    end
    if (state == S_DONE && out_free) begin
      rsp.left_sample    <= swap_channels ? sin_sample : prod_sample;
      rsp.right_sample   <= swap_channels ? prod_sample : sin_sample;
      rsp.carrier_active <= active;
    end
  end

  // sequencer and nco state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      rsp_valid      <= 1'b0;
      step_gain      <= STEP_GAIN_RST;
      quadrature_270 <= 1'b0;
      swap_channels  <= 1'b0;
      link_timeout   <= LINK_TIMEOUT_RST;
      ev             <= '0;
      carrier_step   <= '0;
      phase          <= '0;
      amp            <= '0;
      active         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_STEP_GAIN:    step_gain      <= cfg_data;
          CFG_QUAD_270:     quadrature_270 <= cfg_data[0];
          CFG_SWAP:         swap_channels  <= cfg_data[0];
          CFG_LINK_TIMEOUT: link_timeout   <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (state == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_VEL;
          end
        end
        S_VEL: begin
          if (!req_q.block_start) begin
            state <= S_AMP_MUL;
          end else if (fresh) begin
            ev    <= req_q.rx_velocity;
            state <= S_STEP_MUL;
          end else begin
            state <= S_DECAY_WB;
          end
        end
        S_DECAY_WB: begin
          if (decay_mag <= DEAD_ZONE) begin
            ev <= '0;
          end else begin
            ev <= prod_neg ? VEL_W'(-decay_mag) : decay_mag;
          end
          state <= S_STEP_MUL;
        end
        S_STEP_MUL: begin
          state <= S_STEP_WB;
        end
        S_STEP_WB: begin
          active <= ev_mag > DEAD_ZONE;
          if (ev_mag > DEAD_ZONE) begin
            carrier_step <= prod_neg ? -STEP_W'(step_mag) : STEP_W'(step_mag);
          end else begin
            carrier_step <= '0;
          end
          state <= S_AMP_MUL;
        end
        S_AMP_MUL: begin
          state <= S_AMP_WB;
        end
        S_AMP_WB: begin
          amp   <= prod_neg ? amp - amp_delta : amp + amp_delta;
          state <= S_SIN_MUL;
        end
        S_SIN_MUL: begin
          state <= S_COS_MUL;
        end
        S_COS_MUL: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            phase <= phase + carrier_step[PHASE_W-1:0];
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_DONE)
    else $error("response word appeared outside the final step");

  a_amp_bounded: assert property (@(posedge clk) disable iff (rst)
    amp <= AMP_PEAK)
    else $error("amplitude above peak");

  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    !active |-> carrier_step == '0)
    else $error("phase step nonzero while carrier inactive");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !rsp_valid) |=> rsp_valid && state == S_IDLE)
    else $error("free output register not loaded");

endmodule

// ===== test/tb_quadrature_timecode_carrier_nco.sv =====
module tb_quadrature_timecode_carrier_nco;
  timeunit 1ns;
  timeprecision 1ps;

  import qtcn_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TICK_ROWS = 22;
  localparam longint unsigned HALF_TURN_Q30 = 64'd3373259426;
  localparam int DEAD_ZONE_Q8 = 102;

  typedef struct packed {
    logic        block_start;
    logic [31:0] now_ms;
    logic [31:0] last_packet_ms;
    logic [19:0] velocity;
    logic        typed;
    logic [15:0] left_want;
    logic [15:0] right_want;
    logic        active_want;
  } tick_row_t;

  // typed rows hold the block at zero amplitude, so both samples are zero
  localparam tick_row_t TICK_TABLE [TICK_ROWS] = '{
    '{1'b0, 32'd0, 32'd0, 20'sd0, 1'b1, 16'sd0, 16'sd0, 1'b0},
    '{1'b1, 32'd1000, 32'd0, 20'sd102, 1'b1, 16'sd0, 16'sd0, 1'b0},
    '{1'b1, 32'd3000, 32'd0, -20'sd102, 1'b1, 16'sd0, 16'sd0, 1'b0},
    '{1'b1, 32'd0, 32'd10, 20'sd0, 1'b1, 16'sd0, 16'sd0, 1'b0},
    '{1'b1, 32'd3001, 32'd0, 20'sd524287, 1'b1, 16'sd0, 16'sd0, 1'b0},
    '{1'b1, 32'd5, 32'hffff_fff0, 20'sd524287, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{1'b0, 32'hffff_ffff, 32'hffff_ffff, 20'h80000, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{1'b0, 32'h5555_5555, 32'haaaa_aaaa, 20'sd0, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{1'b0, 32'haaaa_aaaa, 32'h5555_5555, 20'hfffff, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{1'b1, 32'hffff_ffff, 32'hffff_ffff, 20'h80000, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{1'b0, 32'd0, 32'd0, 20'sd0, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{1'b1, 32'd4000, 32'd0, 20'sd0, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{1'b1, 32'h8000_0000, 32'd0, 20'sd0, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{1'b1, 32'd100, 32'd100, 20'sd103, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{1'b0, 32'd0, 32'd0, 20'sd0, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{1'b1, 32'd0, 32'hffff_ffff, 20'sd104, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{1'b1, 32'd10000, 32'd0, 20'sd0, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{1'b0, 32'd0, 32'd0, 20'sd0, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{1'b0, 32'd0, 32'd0, 20'sd0, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{1'b1, 32'd0, 32'd0, 20'sd51200, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{1'b0, 32'd0, 32'd0, 20'sd0, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{1'b0, 32'd0, 32'd0, 20'sd0, 1'b0, 16'sd0, 16'sd0, 1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  req_t                  req = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  rsp_t                  rsp;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of the registers and the carrier state
  int          gain_cfg = int'(STEP_GAIN_RST);
  logic        q270_cfg = 1'b0;
  logic        swap_cfg = 1'b0;
  logic [15:0] timeout_cfg = LINK_TIMEOUT_RST;
  int          vel_q8 = 0;
  int          phase_inc = 0;
  logic [15:0] nco_phase = '0;
  longint      amp_q8 = 0;
  logic        carrier_on = 1'b0;
  int          sine_rom [SINE_DEPTH];

  rsp_t sample_q [$];
  rsp_t want;
  int   n_bad = 0;
  int   n_cycles = 0;
  int   n_sent = 0;
  bit   snd_quiet = 1'b0;

  quadrature_timecode_carrier_nco u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic longint shift_to_zero(longint v, int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = m >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic int sine_value(int i);
    longint unsigned q;
    longint unsigned x;
    longint unsigned term;
    longint unsigned sum;
    bit              neg;
    neg = 1'b0;
    q = longint'((2 * i + 1) % (2 * SINE_DEPTH));
    if (q >= SINE_DEPTH) begin
      neg = 1'b1;
      q = q - SINE_DEPTH;
    end
    if (2 * q > SINE_DEPTH) begin
      q = SINE_DEPTH - q;
    end
    x = q * HALF_TURN_Q30 / SINE_DEPTH;
    term = x;
    sum = x;
    for (int n = 1; n <= 12; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = (sum > term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    sum = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (sum > 64'd32767) begin
      sum = 64'd32767;
    end
    return neg ? -int'(sum) : int'(sum);
  endfunction

  function automatic rsp_t predict_tick(req_t w);
    logic [31:0] age;
    longint      dv;
    longint      mag;
    longint      target;
    longint      s;
    longint      c;
    int          idx;
    int          cidx;
    rsp_t        r;
    if (w.block_start) begin
      age = w.now_ms - w.last_packet_ms;
      if (age <= {16'd0, timeout_cfg}) begin
        vel_q8 = w.rx_velocity;
      end else begin
        dv = shift_to_zero(longint'(vel_q8) * 64225, 16);
        mag = (dv < 0) ? -dv : dv;
        vel_q8 = (mag <= DEAD_ZONE_Q8) ? 0 : int'(dv);
      end
      carrier_on = ((vel_q8 < 0) ? -vel_q8 : vel_q8) > DEAD_ZONE_Q8;
      phase_inc = carrier_on ?
          int'(shift_to_zero(longint'(vel_q8) * longint'(gain_cfg), 24)) : 0;
    end
    idx = int'((longint'(nco_phase) * SINE_DEPTH) >> 16) % SINE_DEPTH;
    cidx = (idx + (q270_cfg ? 3 * SINE_DEPTH / 4 : SINE_DEPTH / 4)) % SINE_DEPTH;
    target = carrier_on ? longint'(PEAK_AMPLITUDE) * 256 : 0;
    amp_q8 = amp_q8 + shift_to_zero((target - amp_q8) * 13107, 16);
    s = shift_to_zero(longint'(sine_rom[idx]) * amp_q8, 23);
    c = shift_to_zero(-longint'(sine_rom[cidx]) * amp_q8, 23);
    r.left_sample = swap_cfg ? 16'(s) : 16'(c);
    r.right_sample = swap_cfg ? 16'(c) : 16'(s);
    r.carrier_active = carrier_on;
    nco_phase = nco_phase + 16'(phase_inc);
    return r;
  endfunction

  function automatic req_t random_tick();
    req_t        w;
    logic [31:0] age;
    int          pick;
    int          v;
    w.block_start = ($urandom_range(0, 3) == 0);
    w.now_ms = $urandom;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      age = $urandom_range(0, 32'(timeout_cfg));
    end else if (pick < 8) begin
      age = 32'(timeout_cfg) + 32'd1 + $urandom_range(0, 5000);
    end else begin
      age = $urandom;
    end
    w.last_packet_ms = w.now_ms - age;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      w.rx_velocity = 20'($urandom);
    end else if (pick < 7) begin
      v = int'($urandom_range(95, 112));
      w.rx_velocity = 20'($urandom_range(0, 1) ? -v : v);
    end else begin
      v = int'($urandom_range(0, 120000)) - 60000;
      w.rx_velocity = 20'(v);
    end
    return w;
  endfunction

  task automatic play_tick(req_t w, bit typed, rsp_t typed_want);
    rsp_t e;
    int   gap;
    if (n_sent % 25 == 0) begin
      snd_quiet = ($urandom_range(0, 3) == 0);
    end
    n_sent++;
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    e = predict_tick(w);
    sample_q.push_back(typed ? typed_want : e);
    gap = snd_quiet ? 0 : int'($urandom_range(0, 8));
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_STEP_GAIN:    gain_cfg = int'(data);
      CFG_QUAD_270:     q270_cfg = data[0];
      CFG_SWAP:         swap_cfg = data[0];
      CFG_LINK_TIMEOUT: timeout_cfg = data[15:0];
      default: ;
    endcase
  endtask

  // high bits beyond each register's width carry noise
  task automatic set_config(logic [23:0] gain, logic q270, logic swap, logic [15:0] tmo);
    write_reg(3'(CFG_LINK_TIMEOUT + 1 + $urandom_range(0, 3)), 24'($urandom));
    write_reg(CFG_STEP_GAIN, gain);
    write_reg(CFG_QUAD_270, {23'($urandom), q270});
    write_reg(CFG_SWAP, {23'($urandom), swap});
    write_reg(CFG_LINK_TIMEOUT, {8'($urandom), tmo});
    cfg_valid <= 1'b0;
  endtask

  task automatic play_random(int count);
    for (int i = 0; i < count; i++) begin
      play_tick(random_tick(), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (sample_q.size() == 0) begin
        if (n_bad < 10) begin
          $display("unexpected word: left %0d right %0d active %0b",
                   rsp.left_sample, rsp.right_sample, rsp.carrier_active);
        end
        n_bad++;
      end else begin
        want = sample_q.pop_front();
        if (rsp.left_sample !== want.left_sample || rsp.right_sample !== want.right_sample
            || rsp.carrier_active !== want.carrier_active) begin
          if (n_bad < 10) begin
            $display("mismatch: expected left %0d right %0d active %0b, got %0d %0d %0b",
                     want.left_sample, want.right_sample, want.carrier_active,
                     rsp.left_sample, rsp.right_sample, rsp.carrier_active);
          end
          n_bad++;
        end
      end
    end
  end

  initial begin
    int pause;
    int taken;
    bit held;
    bit quiet;
    taken = 0;
    held = 1'b0;
    quiet = 1'b0;
    forever begin
      if (taken % 25 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
      end
      pause = quiet ? 0 : int'($urandom_range(0, 8));
      // one long hold so the output fills and the input backs up
      if (!held && taken == 250) begin
        held = 1'b1;
        pause = 80;
      end
      if (pause > 0) begin
        rsp_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (!rsp_valid || rst) @(posedge clk);
      taken++;
    end
  end

  initial begin
    req_t      w;
    tick_row_t row;
    rsp_t      typed_want;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      sine_rom[i] = sine_value(i);
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < TICK_ROWS; i++) begin
      row = TICK_TABLE[i];
      w.block_start = row.block_start;
      w.now_ms = row.now_ms;
      w.last_packet_ms = row.last_packet_ms;
      w.rx_velocity = row.velocity;
      typed_want.left_sample = row.left_want;
      typed_want.right_sample = row.right_want;
      typed_want.carrier_active = row.active_want;
      play_tick(w, row.typed, typed_want);
    end
    play_random(80);

    drain();
    set_config(24'hffffff, 1'b1, 1'b1, 16'd0);
    play_random(100);

    drain();
    set_config(24'd0, 1'b0, 1'b0, 16'hffff);
    play_random(100);

    for (int p = 0; p < 2; p++) begin
      drain();
      set_config(24'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
      play_random(110);
    end

    drain();
    if (n_bad == 0 && sample_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== quadrature_timecode_carrier_nco.f =====
rtl/qtcn_pkg.sv
rtl/quadrature_timecode_carrier_nco.sv
test/tb_quadrature_timecode_carrier_nco.sv
